@@ src/cscan_pkg.sv @@
package cscan_pkg;

    // Default width of the line counter.
    localparam int LINE_BITS_DEF = 32;

    // Result queue geometry. One byte can cause up to three results.
    localparam int MAX_RESULTS = 3;
    localparam int QDEPTH      = 8;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    // Event kinds.
    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_CHAR  = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    // Comment styles.
    localparam logic [1:0] ST_HASH   = 2'd0;
    localparam logic [1:0] ST_SLASH  = 2'd1;
    localparam logic [1:0] ST_BLOCK  = 2'd2;
    localparam logic [1:0] ST_DOLLAR = 2'd3;

    // Scanner modes.
    localparam logic [2:0] MD_TEXT   = 3'd0;
    localparam logic [2:0] MD_SLASH  = 3'd1;
    localparam logic [2:0] MD_HASH   = 3'd2;
    localparam logic [2:0] MD_LINE   = 3'd3;
    localparam logic [2:0] MD_BLOCK  = 3'd4;
    localparam logic [2:0] MD_STAR   = 3'd5;
    localparam logic [2:0] MD_DOLLAR = 3'd6;

    // Characters of interest.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    // One result as it is held in the queue.
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  style;
        logic [31:0] line;
        logic [7:0]  ch;
        logic        last;
    } event_t;

endpackage

@@ src/comment_scanner_unit.sv @@
// The results of a byte are registered in the result queue and shown from its head.
// Throughput: one byte per cycle while item_ready is high; the output moves one result
// per cycle while event_ready is high, and each of a byte's results needs its own pop.
// An eight-entry result queue parts the two sides; item_ready drops when fewer than
// three entries are free.
// Reset: mode returns to plain text, the line count to one, and the queue empties.
module comment_scanner_unit #(
    parameter int LINE_BITS = cscan_pkg::LINE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] char_in,
    input  logic       end_of_text,
    output logic       event_valid,
    input  logic       event_ready,
    output logic [1:0] event_kind,
    output logic [1:0] comment_style,
    output logic [31:0] line_number,
    output logic [7:0] body_char,
    output logic       run_last
);
    import cscan_pkg::*;

    localparam logic [QCNT_W-1:0] READY_MAX = QCNT_W'(QDEPTH - MAX_RESULTS);
    localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QDEPTH);
    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    logic [2:0]           mode_reg, mode_next;
    logic [LINE_BITS-1:0] line_reg, line_next;

    event_t               ev [MAX_RESULTS];
    logic [1:0]           ev_n;

    event_t               queue_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;

    logic push, pop;

    // Clamp the line count to the 32-bit report field.
    function automatic logic [31:0] clamp_line(input logic [LINE_BITS-1:0] v);
        logic hi_any;
        hi_any = (v >> 32) != '0;
        return hi_any ? 32'hFFFF_FFFF : 32'(v);
    endfunction

    function automatic event_t make_ev(input logic [1:0] kind, input logic [1:0] style,
                                       input logic [LINE_BITS-1:0] ln, input logic [7:0] ch);
        event_t e;
        e.kind  = kind;
        e.style = style;
        e.line  = clamp_line(ln);
        e.ch    = ch;
        e.last  = 1'b0;
        return e;
    endfunction

    // Scanner step: works out the results of one byte and the next mode and line.
    always_comb
    begin
        logic [2:0]           md;
        logic [LINE_BITS-1:0] ln;
        logic [1:0]           n;
        logic                 fall;
        logic [1:0]           sty;

        md   = mode_reg;
        ln   = line_reg;
        n    = 2'd0;
        fall = 1'b0;
        sty  = ST_HASH;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            ev[k] = make_ev(EV_START, ST_HASH, LINE_ONE, CH_NUL);
        end

        if (char_in != CH_NUL)
        begin
            // First look at modes that resolve a pending character.
            case (mode_reg)
                MD_SLASH:
                begin
                    if (char_in == CH_STAR)
                    begin
                        ev[n] = make_ev(EV_START, ST_BLOCK, ln, CH_NUL);
                        n = n + 2'd1;
                        md = MD_BLOCK;
                    end
                    else if (char_in == CH_SLASH)
                    begin
                        ev[n] = make_ev(EV_START, ST_SLASH, ln, CH_NUL);
                        n = n + 2'd1;
                        md = MD_LINE;
                    end
                    else
                    begin
                        md = MD_TEXT;
                        fall = 1'b1;
                    end
                end
                MD_STAR:
                begin
                    if (char_in == CH_SLASH)
                    begin
                        ev[n] = make_ev(EV_END, ST_BLOCK, ln, CH_NUL);
                        n = n + 2'd1;
                        md = MD_TEXT;
                    end
                    else if (char_in == CH_STAR)
                    begin
                        ev[n] = make_ev(EV_CHAR, ST_BLOCK, ln, CH_STAR);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        ev[n] = make_ev(EV_CHAR, ST_BLOCK, ln, CH_STAR);
                        n = n + 2'd1;
                        md = MD_BLOCK;
                        fall = 1'b1;
                    end
                end
                MD_HASH, MD_LINE, MD_BLOCK, MD_DOLLAR:
                begin
                    fall = 1'b1;
                end
                default:
                begin
                    md = MD_TEXT;
                    fall = 1'b1;
                end
            endcase

            // Then handle the byte in the mode that applies to it.
            if (fall)
            begin
                case (md)
                    MD_HASH, MD_LINE:
                    begin
                        sty = (md == MD_HASH) ? ST_HASH : ST_SLASH;
                        if (char_in == CH_NL)
                        begin
                            ev[n] = make_ev(EV_END, sty, ln, CH_NUL);
                            n = n + 2'd1;
                            if (ln != '1)
                                ln = ln + LINE_ONE;
                            md = MD_TEXT;
                        end
                        else
                        begin
                            ev[n] = make_ev(EV_CHAR, sty, ln, char_in);
                            n = n + 2'd1;
                        end
                    end
                    MD_BLOCK:
                    begin
                        if (char_in == CH_STAR)
                        begin
                            md = MD_STAR;
                        end
                        else
                        begin
                            ev[n] = make_ev(EV_CHAR, ST_BLOCK, ln, char_in);
                            n = n + 2'd1;
                            if (char_in == CH_NL && ln != '1)
                                ln = ln + LINE_ONE;
                        end
                    end
                    MD_DOLLAR:
                    begin
                        if (char_in == CH_DOLLAR)
                        begin
                            ev[n] = make_ev(EV_END, ST_DOLLAR, ln, CH_NUL);
                            n = n + 2'd1;
                            md = MD_TEXT;
                        end
                        else
                        begin
                            ev[n] = make_ev(EV_CHAR, ST_DOLLAR, ln, char_in);
                            n = n + 2'd1;
                            if (char_in == CH_NL && ln != '1)
                                ln = ln + LINE_ONE;
                        end
                    end
                    default:
                    begin
                        // Plain text.
                        if (char_in == CH_HASH)
                        begin
                            ev[n] = make_ev(EV_START, ST_HASH, ln, CH_NUL);
                            n = n + 2'd1;
                            md = MD_HASH;
                        end
                        else if (char_in == CH_SLASH)
                        begin
                            md = MD_SLASH;
                        end
                        else if (char_in == CH_DOLLAR)
                        begin
                            ev[n] = make_ev(EV_START, ST_DOLLAR, ln, CH_NUL);
                            n = n + 2'd1;
                            md = MD_DOLLAR;
                        end
                        else if (char_in == CH_NL && ln != '1)
                        begin
                            ln = ln + LINE_ONE;
                        end
                    end
                endcase
            end
        end

        // End of file: close or flag whatever is still open, then start over.
        if (char_in == CH_NUL || end_of_text)
        begin
            case (md)
                MD_HASH:
                begin
                    ev[n] = make_ev(EV_END, ST_HASH, ln, CH_NUL);
                    n = n + 2'd1;
                end
                MD_LINE:
                begin
                    ev[n] = make_ev(EV_END, ST_SLASH, ln, CH_NUL);
                    n = n + 2'd1;
                end
                MD_STAR:
                begin
                    ev[n] = make_ev(EV_CHAR, ST_BLOCK, ln, CH_STAR);
                    n = n + 2'd1;
                    ev[n] = make_ev(EV_ERROR, ST_BLOCK, ln, CH_NUL);
                    n = n + 2'd1;
                end
                MD_BLOCK:
                begin
                    ev[n] = make_ev(EV_ERROR, ST_BLOCK, ln, CH_NUL);
                    n = n + 2'd1;
                end
                MD_DOLLAR:
                begin
                    ev[n] = make_ev(EV_ERROR, ST_DOLLAR, ln, CH_NUL);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            md = MD_TEXT;
            ln = LINE_ONE;
        end

        // Mark the final result of this byte.
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            ev[k].last = (2'(k) == n - 2'd1);
        end

        mode_next = md;
        line_next = ln;
        ev_n      = n;
    end

    // Handshake and queue bookkeeping.
    assign item_ready  = count_reg <= READY_MAX;
    assign event_valid = count_reg != '0;
    assign push        = item_valid && item_ready;
    assign pop         = event_valid && event_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(ev_n);
            count_next  = count_next + QCNT_W'(ev_n);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
            count_next  = count_next - QCNT_W'(1);
        end
    end

    // Scanner state and queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MD_TEXT;
            line_reg   <= LINE_ONE;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                mode_reg <= mode_next;
                line_reg <= line_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage: the results of one transfer land in consecutive entries.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                if (2'(k) < ev_n)
                begin
                    queue_reg[wr_ptr_reg + QPTR_W'(k)] <= ev[k];
                end
            end
        end
    end

    // Output side shows the head of the queue.
    assign event_kind    = queue_reg[rd_ptr_reg].kind;
    assign comment_style = queue_reg[rd_ptr_reg].style;
    assign line_number   = queue_reg[rd_ptr_reg].line;
    assign body_char     = queue_reg[rd_ptr_reg].ch;
    assign run_last      = queue_reg[rd_ptr_reg].last;

`ifndef SYNTHESIS
    // The queue never holds more entries than it has.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("result queue count exceeds depth");

    // The last byte of a file leaves the scanner in plain text on line one.
    a_file_reset: assert property (@(posedge clk) disable iff (!rst_n)
        push && (char_in == CH_NUL || end_of_text)
        |=> mode_reg == MD_TEXT && line_reg == LINE_ONE)
        else $error("scanner state not restored after end of file");

    // Only character events carry a body byte.
    a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_kind != EV_CHAR |-> body_char == CH_NUL)
        else $error("non-character event carries a body byte");

    // With no transfer on either side the queue fill stays put.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !push && !pop |=> $stable(count_reg))
        else $error("queue count moved without a transfer");
`endif

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    import cscan_pkg::*;

    localparam int RANDOM_ITEMS = 260;
    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    logic [7:0]  char_in;
    logic        end_of_text;
    logic        event_valid;
    logic        event_ready;
    logic [1:0]  event_kind;
    logic [1:0]  comment_style;
    logic [31:0] line_number;
    logic [7:0]  body_char;
    logic        run_last;

    // Controls shared by the sender, the receiver and the main sequence, plus monitor state.
    bit          tx_no_gap;
    bit          rx_no_gap;
    bit          hold_out;
    int          active_items;
    int          idle_cycles;
    event_t      seen_event;

    // Scanner state model and the queue of events it expects the block to produce.
    class comment_event_board;
        event_t      pending_events[$];
        event_t      step_events[$];
        logic [2:0]  mode;
        logic [31:0] line_cnt;
        logic [31:0] open_line;
        int          mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            mode      = MD_TEXT;
            line_cnt  = 32'd1;
            open_line = 32'd1;
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        function void push_event(logic [1:0] kind, logic [1:0] style, logic [31:0] line,
                                 logic [7:0] ch);
            event_t ev;
            if (step_events.size() < MAX_RESULTS)
            begin
                ev.kind  = kind;
                ev.style = style;
                ev.line  = line;
                ev.ch    = ch;
                ev.last  = 1'b0;
                step_events.push_back(ev);
            end
        endfunction

        // The line counter sticks at its top value.
        function void bump_line();
            if (line_cnt != '1)
                line_cnt = line_cnt + 32'd1;
        endfunction

        function void open_comment(logic [1:0] style, logic [2:0] next_mode);
            open_line = line_cnt;
            push_event(EV_START, style, open_line, 8'h00);
            mode = next_mode;
        endfunction

        function void text_char(logic [7:0] c);
            if (c == CH_HASH)
                open_comment(ST_HASH, MD_HASH);
            else if (c == CH_SLASH)
                mode = MD_SLASH;
            else if (c == CH_DOLLAR)
                open_comment(ST_DOLLAR, MD_DOLLAR);
            else if (c == CH_NL)
                bump_line();
        endfunction

        function void add_body(logic [1:0] style, logic [7:0] c);
            push_event(EV_CHAR, style, line_cnt, c);
            if (c == CH_NL)
                bump_line();
        endfunction

        // A star inside a block comment waits for the next byte.
        function void block_char(logic [7:0] c);
            if (c == CH_STAR)
                mode = MD_STAR;
            else
                add_body(ST_BLOCK, c);
        endfunction

        function void line_comment_char(logic [1:0] style, logic [7:0] c);
            if (c == CH_NL)
            begin
                push_event(EV_END, style, line_cnt, 8'h00);
                bump_line();
                mode = MD_TEXT;
            end
            else
            begin
                add_body(style, c);
            end
        endfunction

        // End of a file: close or flag the open comment, then start over.
        function void close_file();
            case (mode)
                MD_HASH:   push_event(EV_END, ST_HASH, line_cnt, 8'h00);
                MD_LINE:   push_event(EV_END, ST_SLASH, line_cnt, 8'h00);
                MD_STAR:
                begin
                    push_event(EV_CHAR, ST_BLOCK, line_cnt, CH_STAR);
                    push_event(EV_ERROR, ST_BLOCK, line_cnt, 8'h00);
                end
                MD_BLOCK:  push_event(EV_ERROR, ST_BLOCK, line_cnt, 8'h00);
                MD_DOLLAR: push_event(EV_ERROR, ST_DOLLAR, line_cnt, 8'h00);
                default:   ;
            endcase
            restart();
        endfunction

        // Note one accepted byte and queue the events that it causes.
        function void scan_byte(logic [7:0] c, logic eot);
            event_t      ev;
            step_events.delete();
            if (c == CH_NUL)
            begin
                close_file();
            end
            else
            begin
                case (mode)
                    MD_SLASH:
                    begin
                        if (c == CH_STAR)
                            open_comment(ST_BLOCK, MD_BLOCK);
                        else if (c == CH_SLASH)
                            open_comment(ST_SLASH, MD_LINE);
                        else
                        begin
                            mode = MD_TEXT;
                            text_char(c);
                        end
                    end
                    MD_HASH:  line_comment_char(ST_HASH, c);
                    MD_LINE:  line_comment_char(ST_SLASH, c);
                    MD_BLOCK: block_char(c);
                    MD_STAR:
                    begin
                        if (c == CH_SLASH)
                        begin
                            push_event(EV_END, ST_BLOCK, line_cnt, 8'h00);
                            mode = MD_TEXT;
                        end
                        else if (c == CH_STAR)
                        begin
                            push_event(EV_CHAR, ST_BLOCK, line_cnt, CH_STAR);
                        end
                        else
                        begin
                            push_event(EV_CHAR, ST_BLOCK, line_cnt, CH_STAR);
                            mode = MD_BLOCK;
                            block_char(c);
                        end
                    end
                    MD_DOLLAR:
                    begin
                        if (c == CH_DOLLAR)
                        begin
                            push_event(EV_END, ST_DOLLAR, line_cnt, 8'h00);
                            mode = MD_TEXT;
                        end
                        else
                        begin
                            add_body(ST_DOLLAR, c);
                        end
                    end
                    default:
                    begin
                        mode = MD_TEXT;
                        text_char(c);
                    end
                endcase
                if (eot)
                    close_file();
            end
            // Mark the final event of this byte.
            if (step_events.size() > 0)
            begin
                ev = step_events.pop_back();
                ev.last = 1'b1;
                step_events.push_back(ev);
            end
            foreach (step_events[k])
                pending_events.push_back(step_events[k]);
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compare one event transfer with the oldest expected event.
        task check_event(input event_t got);
            event_t want;
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected event kind=%0d style=%0d line=%0d",
                                          got.kind, got.style, got.line));
                return;
            end
            want = pending_events.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("event_kind got %0d want %0d", got.kind, want.kind));
            if (got.style !== want.style)
                report_mismatch($sformatf("comment_style got %0d want %0d",
                                          got.style, want.style));
            if (got.line !== want.line)
                report_mismatch($sformatf("line_number got %0d want %0d", got.line, want.line));
            if (got.ch !== want.ch)
                report_mismatch($sformatf("body_char got %02h want %02h", got.ch, want.ch));
            if (got.last !== want.last)
                report_mismatch($sformatf("run_last got %0d want %0d", got.last, want.last));
        endtask
    endclass

    comment_event_board board = new();

    comment_scanner_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .char_in       (char_in),
        .end_of_text   (end_of_text),
        .event_valid   (event_valid),
        .event_ready   (event_ready),
        .event_kind    (event_kind),
        .comment_style (comment_style),
        .line_number   (line_number),
        .body_char     (body_char),
        .run_last      (run_last)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watch both channels at every rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (event_valid && event_ready)
            begin
                seen_event.kind  = event_kind;
                seen_event.style = comment_style;
                seen_event.line  = line_number;
                seen_event.ch    = body_char;
                seen_event.last  = run_last;
                board.check_event(seen_event);
            end
            if (item_valid && item_ready)
            begin
                board.scan_byte(char_in, end_of_text);
                active_items++;
            end
        end
    end

    // End the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (event_valid && event_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Event receiver with random stalls and one long hold-off on request.
    initial
    begin
        int gap;
        event_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_out)
            begin
                gap = HOLD_CYCLES;
                hold_out = 1'b0;
            end
            else
                gap = rx_no_gap ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                event_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            event_ready <= 1'b1;
            @(posedge clk);
            while (!event_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Offer one byte after a random gap (none while tx_no_gap is set) and wait for its transfer.
    task automatic send_byte(input logic [7:0] ch, input logic eot);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid  <= 1'b1;
        char_in     <= ch;
        end_of_text <= eot;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(input string text, input bit eot_last);
        for (int k = 0; k < text.len(); k++)
            send_byte(text[k], eot_last && (k == text.len() - 1));
    endtask

    // Random comment body byte that never equals the given terminator or zero.
    function automatic logic [7:0] body_byte(input logic [7:0] stop);
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: b = 8'(8'h61 + $urandom_range(0, 25));
            5:             b = CH_NL;
            6:             b = CH_STAR;
            7:
            begin
                case ($urandom_range(0, 2))
                    0:       b = CH_SLASH;
                    1:       b = CH_HASH;
                    default: b = CH_DOLLAR;
                endcase
            end
            default:       b = 8'($urandom_range(1, 255));
        endcase
        if (b == stop || b == CH_NUL)
            b = 8'h78;
        return b;
    endfunction

    // Build one random fragment of source text and send it.
    task automatic send_fragment();
        logic [7:0] frag[$];
        int         len;
        int         opener;
        bit         file_end;
        bit         nul_end;
        len      = $urandom_range(0, 6);
        file_end = ($urandom_range(0, 9) == 0);
        nul_end  = 1'b0;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                frag.push_back(CH_HASH);
                repeat (len) frag.push_back(body_byte(CH_NL));
                frag.push_back(CH_NL);
            end
            2:
            begin
                frag.push_back(CH_SLASH);
                frag.push_back(CH_SLASH);
                repeat (len) frag.push_back(body_byte(CH_NL));
                frag.push_back(CH_NL);
            end
            3, 4:
            begin
                frag.push_back(CH_SLASH);
                frag.push_back(CH_STAR);
                repeat (len) frag.push_back(body_byte(CH_NUL));
                frag.push_back(CH_STAR);
                frag.push_back(CH_SLASH);
            end
            5:
            begin
                frag.push_back(CH_DOLLAR);
                repeat (len) frag.push_back(body_byte(CH_DOLLAR));
                frag.push_back(CH_DOLLAR);
            end
            6:
            begin
                repeat (len + 1) frag.push_back(8'($urandom_range(1, 255)));
            end
            7:
            begin
                // Noise with an occasional terminator byte.
                repeat (len + 1)
                    frag.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : body_byte(CH_NUL));
            end
            8:
            begin
                // A comment, or a lone slash, cut short by the end of the file.
                opener = $urandom_range(0, 4);
                if (opener == 0)
                    frag.push_back(CH_HASH);
                else if (opener == 3)
                    frag.push_back(CH_DOLLAR);
                else
                    frag.push_back(CH_SLASH);
                if (opener == 1)
                    frag.push_back(CH_SLASH);
                if (opener == 2)
                    frag.push_back(CH_STAR);
                if (opener != 4)
                    repeat (len)
                        frag.push_back(body_byte((opener == 3) ? CH_DOLLAR :
                                                 (opener == 2) ? CH_NUL : CH_NL));
                if (opener == 2 && $urandom_range(0, 1))
                    frag.push_back(CH_STAR);
                nul_end  = ($urandom_range(0, 2) == 0);
                file_end = !nul_end;
            end
            default:
            begin
                repeat (len + 1) frag.push_back(CH_NL);
            end
        endcase
        if (nul_end)
            frag.push_back(CH_NUL);
        foreach (frag[i])
            send_byte(frag[i], file_end && (i == frag.size() - 1));
    endtask

    // Main sequence: reset, directed text, then random fragments.
    initial
    begin
        int frag_count;
        item_valid   = 1'b0;
        char_in      = 8'h00;
        end_of_text  = 1'b0;
        tx_no_gap    = 1'b0;
        rx_no_gap    = 1'b0;
        hold_out     = 1'b0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Each comment style, a lone slash, held stars and the ways a file can end.
        send_text("#a\n", 1'b0);
        send_text("//\n", 1'b0);
        send_text("/#\n", 1'b0);
        send_text("/**x**/", 1'b0);
        send_text("$\n$", 1'b0);
        send_text("#z", 1'b1);
        send_text("/**a", 1'b1);
        send_text("$q", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(8'hFF, 1'b1);

        frag_count = 0;
        while (active_items < RANDOM_ITEMS)
        begin
            if (frag_count == 10)
            begin
                // The receiver holds off while a long comment fills the result queue.
                hold_out  = 1'b1;
                tx_no_gap = 1'b1;
                send_byte(CH_HASH, 1'b0);
                repeat (24) send_byte(body_byte(CH_NL), 1'b0);
                send_byte(CH_NL, 1'b0);
                tx_no_gap = 1'b0;
            end
            if (frag_count == 20)
            begin
                // The sender waits until every expected event has come out.
                item_valid <= 1'b0;
                @(negedge clk);
                while (board.pending() != 0) @(negedge clk);
            end
            tx_no_gap = (frag_count >= 25 && frag_count < 35);
            rx_no_gap = tx_no_gap;
            send_fragment();
            frag_count++;
        end
        item_valid <= 1'b0;
        tx_no_gap = 1'b0;
        rx_no_gap = 1'b0;

        // Let the last events drain, then check that none are left over.
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending() != 0)
            board.report_mismatch("expected events left over");
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
